### src/i2c_ram_pkg.sv
// Shared types, constants and decode functions for the I2C register access master.
package i2c_ram_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
	localparam logic [7:0] READ_FLAG = 8'h01;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_TICK
	} cmd_t;

	typedef enum logic [1:0] {
		EL_START,
		EL_WBYTE,
		EL_RBYTE,
		EL_STOP
	} elem_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEG1,
		PH_SEG2,
		PH_SEG3
	} phase_t;

	// One classified tick as it travels through the queue.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] dev_addr;
		logic [7:0] reg_index;
		logic [7:0] write_value;
		logic       sda_in;
	} tick_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       rejected;
	} pin_item_t;

	// Which bus element a transaction step stands for.
	function automatic elem_t elem_kind(input logic is_read, input logic [2:0] step);
		elem_t kind;
		if (is_read) begin
			case (step)
				3'd0, 3'd3:       kind = EL_START;
				3'd1, 3'd2, 3'd4: kind = EL_WBYTE;
				3'd5:             kind = EL_RBYTE;
				default:          kind = EL_STOP;
			endcase
		end else begin
			case (step)
				3'd0:             kind = EL_START;
				3'd1, 3'd2, 3'd3: kind = EL_WBYTE;
				default:          kind = EL_STOP;
			endcase
		end
		return kind;
	endfunction

	// Byte sent by a write-byte step.
	function automatic logic [7:0] elem_byte(input logic is_read, input logic [2:0] step,
			input logic [7:0] dev, input logic [7:0] idx, input logic [7:0] val);
		logic [7:0] b;
		if (step == 3'd1) begin
			b = dev;
		end else if (step == 3'd2) begin
			b = idx;
		end else if (is_read) begin
			b = dev | READ_FLAG;
		end else begin
			b = val;
		end
		return b;
	endfunction

endpackage

### src/i2c_ram_ifs.sv
// Valid/ready channel interfaces for the tick input and the pin result.
interface i2c_ram_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] dev_addr;
	logic [7:0] reg_index;
	logic [7:0] write_value;
	logic       sda_in;

	modport source (output valid, output mode, output dev_addr, output reg_index,
		output write_value, output sda_in, input ready);
	modport sink (input valid, input mode, input dev_addr, input reg_index,
		input write_value, input sda_in, output ready);
endinterface

interface i2c_ram_pin_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, output scl_out, output sda_out, output sda_drive,
		output busy_res, output done_res, output read_data, output rejected, input ready);
	modport sink (input valid, input scl_out, input sda_out, input sda_drive,
		input busy_res, input done_res, input read_data, input rejected, output ready);
endinterface

### src/i2c_register_access_master_top.sv
// Top level of the I2C register access master: front stage, queue and bus engine.
//
//   channel    dir  transfer                               payload
//   tick_ch    in   one bus tick (command or plain tick)   mode, bytes, sda_in
//   pin_ch     out  pin state for that tick                pins, status, read_data
//   cfg        in   phase_ticks write, cfg_we/cfg_wdata    8-bit phase length
//
// One tick transfer is taken every cycle unless the pin channel stalls; each yields one
// pin transfer. From tick acceptance to result valid the item passes the front register,
// the queue and the output register. The bus engine advances its segment counters once per
// tick. Reset returns the engine to idle with phase_ticks at 2.
// A stalled pin channel fills the output register, then the queue, then the front stage.
module i2c_register_access_master_top #(
	parameter int QUEUE_DEPTH = i2c_ram_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	i2c_ram_tick_if.sink  tick_ch,
	i2c_ram_pin_if.source pin_ch
);

	logic                    push_valid;
	logic                    push_ready;
	i2c_ram_pkg::tick_item_t push_data;
	logic                    pop_valid;
	logic                    pop_ready;
	i2c_ram_pkg::tick_item_t pop_data;

	i2c_ram_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_ch    (tick_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	i2c_ram_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	i2c_ram_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pin_ch    (pin_ch)
	);

endmodule

### src/i2c_ram_front.sv
// Front stage: takes tick transfers, decodes the mode and registers the item.
module i2c_ram_front (
	input  logic                    clk,
	input  logic                    arst_n,
	i2c_ram_tick_if.sink            tick_ch,
	output logic                    push_valid,
	input  logic                    push_ready,
	output i2c_ram_pkg::tick_item_t push_data
);

	logic                    valid_s1;
	i2c_ram_pkg::tick_item_t item_s1;
	i2c_ram_pkg::cmd_t       cmd_c;

	assign tick_ch.ready = !valid_s1 || push_ready;

	// Mode three behaves as a plain tick.
	always_comb begin
		unique case (i2c_ram_pkg::mode_t'(tick_ch.mode))
			i2c_ram_pkg::MODE_WRITE: cmd_c = i2c_ram_pkg::CMD_WRITE;
			i2c_ram_pkg::MODE_READ:  cmd_c = i2c_ram_pkg::CMD_READ;
			default:                 cmd_c = i2c_ram_pkg::CMD_TICK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ch.ready) begin
			valid_s1 <= tick_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ch.valid && tick_ch.ready) begin
			item_s1.cmd         <= cmd_c;
			item_s1.dev_addr    <= tick_ch.dev_addr;
			item_s1.reg_index   <= tick_ch.reg_index;
			item_s1.write_value <= tick_ch.write_value;
			item_s1.sda_in      <= tick_ch.sda_in;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = item_s1;

endmodule

### src/i2c_ram_fifo.sv
// Small queue that decouples the front stage from the bus engine.
module i2c_ram_fifo #(
	parameter int DEPTH = i2c_ram_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  i2c_ram_pkg::tick_item_t push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output i2c_ram_pkg::tick_item_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	i2c_ram_pkg::tick_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/i2c_ram_back.sv
// Bus engine: runs the START, byte, ACK and STOP segments one tick per item.
module i2c_ram_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_wdata,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  i2c_ram_pkg::tick_item_t pop_data,
	i2c_ram_pin_if.source           pin_ch
);

	logic [7:0]            phase_ticks_q;
	i2c_ram_pkg::phase_t   phase_q;
	logic [7:0]            tick_count_q;
	logic [3:0]            bit_count_q;
	logic [2:0]            byte_step_q;
	logic [7:0]            shift_byte_q;
	logic [7:0]            dev_q;
	logic [7:0]            idx_q;
	logic [7:0]            val_q;
	logic                  is_read_q;
	logic [7:0]            last_read_q;
	logic                  out_valid_q;
	i2c_ram_pkg::pin_item_t out_q;

	// State as seen by this tick, after an accepted command and the segment clamps.
	logic                  take_cmd;
	i2c_ram_pkg::phase_t   e_phase;
	logic [7:0]            e_tick;
	logic [3:0]            e_bits;
	logic [2:0]            e_step;
	logic [7:0]            e_shift;
	logic [7:0]            e_dev;
	logic [7:0]            e_idx;
	logic [7:0]            e_val;
	logic                  e_read;
	i2c_ram_pkg::elem_t    kind;

	i2c_ram_pkg::phase_t   n_phase;
	logic [7:0]            n_tick;
	logic [3:0]            n_bits;
	logic [2:0]            n_step;
	logic [7:0]            n_shift;
	logic [7:0]            n_last_read;
	logic                  done_c;
	logic [7:0]            limit;
	logic                  seg_end;
	logic [2:0]            next_step;
	i2c_ram_pkg::pin_item_t pins_c;

	logic                  step_en;

	assign pop_ready = !out_valid_q || pin_ch.ready;
	assign step_en   = pop_valid && pop_ready;

	always_comb begin
		take_cmd = (pop_data.cmd != i2c_ram_pkg::CMD_TICK) && (phase_q == i2c_ram_pkg::PH_IDLE);
		if (take_cmd) begin
			e_phase = i2c_ram_pkg::PH_SEG1;
			e_tick  = '0;
			e_bits  = '0;
			e_step  = '0;
			e_shift = '0;
			e_dev   = pop_data.dev_addr;
			e_idx   = pop_data.reg_index;
			e_val   = pop_data.write_value;
			e_read  = pop_data.cmd == i2c_ram_pkg::CMD_READ;
		end else begin
			e_phase = phase_q;
			e_tick  = tick_count_q;
			e_bits  = bit_count_q;
			e_step  = byte_step_q;
			e_shift = shift_byte_q;
			e_dev   = dev_q;
			e_idx   = idx_q;
			e_val   = val_q;
			e_read  = is_read_q;
		end
		kind = i2c_ram_pkg::elem_kind(e_read, e_step);
		// Byte elements have only two segments per bit.
		if (e_phase == i2c_ram_pkg::PH_SEG3 && kind != i2c_ram_pkg::EL_START &&
				kind != i2c_ram_pkg::EL_STOP) begin
			e_phase = i2c_ram_pkg::PH_SEG1;
		end
		if (e_bits > i2c_ram_pkg::BITS_PER_BYTE) begin
			e_bits = i2c_ram_pkg::BITS_PER_BYTE;
		end
	end

	// Next state.
	always_comb begin
		limit       = (phase_ticks_q == '0) ? 8'd1 : phase_ticks_q;
		seg_end     = ({1'b0, e_tick} + 9'd1) >= {1'b0, limit};
		next_step   = e_step + 3'd1;
		n_phase     = e_phase;
		n_tick      = e_tick;
		n_bits      = e_bits;
		n_step      = e_step;
		n_shift     = e_shift;
		n_last_read = last_read_q;
		done_c      = 1'b0;
		if (e_phase != i2c_ram_pkg::PH_IDLE) begin
			if (!seg_end) begin
				n_tick = e_tick + 8'd1;
			end else begin
				n_tick = '0;
				if ((kind == i2c_ram_pkg::EL_START && e_phase == i2c_ram_pkg::PH_SEG3) ||
						((kind == i2c_ram_pkg::EL_WBYTE || kind == i2c_ram_pkg::EL_RBYTE) &&
						e_phase == i2c_ram_pkg::PH_SEG2 &&
						e_bits >= i2c_ram_pkg::BITS_PER_BYTE)) begin
					// The element is over: move on to the next one.
					if (kind == i2c_ram_pkg::EL_RBYTE) begin
						n_last_read = e_shift;
					end
					n_step  = next_step;
					n_phase = i2c_ram_pkg::PH_SEG1;
					n_bits  = '0;
					if (i2c_ram_pkg::elem_kind(e_read, next_step) == i2c_ram_pkg::EL_WBYTE) begin
						n_shift = i2c_ram_pkg::elem_byte(e_read, next_step, e_dev, e_idx, e_val);
					end else begin
						n_shift = '0;
					end
				end else if (kind == i2c_ram_pkg::EL_START) begin
					n_phase = i2c_ram_pkg::phase_t'(e_phase + 2'd1);
				end else if (kind == i2c_ram_pkg::EL_STOP) begin
					if (e_phase == i2c_ram_pkg::PH_SEG3) begin
						done_c  = 1'b1;
						n_phase = i2c_ram_pkg::PH_IDLE;
						n_step  = '0;
						n_bits  = '0;
					end else begin
						n_phase = i2c_ram_pkg::phase_t'(e_phase + 2'd1);
					end
				end else if (e_phase == i2c_ram_pkg::PH_SEG1) begin
					n_phase = i2c_ram_pkg::PH_SEG2;
				end else begin
					// End of a bit slot: read bits are sampled on this last high tick.
					if (kind == i2c_ram_pkg::EL_RBYTE) begin
						n_shift = {e_shift[6:0], pop_data.sda_in};
					end else begin
						n_shift = {e_shift[6:0], 1'b0};
					end
					n_bits  = e_bits + 4'd1;
					n_phase = i2c_ram_pkg::PH_SEG1;
				end
			end
		end
	end

	// Pin levels for this tick.
	always_comb begin
		pins_c.scl_out   = 1'b1;
		pins_c.sda_out   = 1'b1;
		pins_c.sda_drive = 1'b0;
		pins_c.busy_res  = e_phase != i2c_ram_pkg::PH_IDLE;
		pins_c.done_res  = done_c;
		pins_c.read_data = n_last_read;
		pins_c.rejected  = (pop_data.cmd != i2c_ram_pkg::CMD_TICK) &&
			(phase_q != i2c_ram_pkg::PH_IDLE);
		if (e_phase != i2c_ram_pkg::PH_IDLE) begin
			pins_c.scl_out = e_phase != i2c_ram_pkg::PH_SEG1;
			unique case (kind)
				i2c_ram_pkg::EL_START: begin
					pins_c.sda_out   = e_phase != i2c_ram_pkg::PH_SEG3;
					pins_c.sda_drive = 1'b1;
				end
				i2c_ram_pkg::EL_STOP: begin
					pins_c.sda_out   = e_phase == i2c_ram_pkg::PH_SEG3;
					pins_c.sda_drive = 1'b1;
				end
				i2c_ram_pkg::EL_WBYTE: begin
					if (e_bits < i2c_ram_pkg::BITS_PER_BYTE) begin
						pins_c.sda_out   = e_shift[7];
						pins_c.sda_drive = 1'b1;
					end
				end
				default: begin
					pins_c.sda_out = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2c_ram_pkg::PHASE_TICKS_RESET;
			phase_q       <= i2c_ram_pkg::PH_IDLE;
			tick_count_q  <= '0;
			bit_count_q   <= '0;
			byte_step_q   <= '0;
			shift_byte_q  <= '0;
			dev_q         <= '0;
			idx_q         <= '0;
			val_q         <= '0;
			is_read_q     <= 1'b0;
			last_read_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_wdata;
			end
			if (step_en) begin
				phase_q      <= n_phase;
				tick_count_q <= n_tick;
				bit_count_q  <= n_bits;
				byte_step_q  <= n_step;
				shift_byte_q <= n_shift;
				dev_q        <= e_dev;
				idx_q        <= e_idx;
				val_q        <= e_val;
				is_read_q    <= e_read;
				last_read_q  <= n_last_read;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= pins_c;
		end
	end

	assign pin_ch.valid     = out_valid_q;
	assign pin_ch.scl_out   = out_q.scl_out;
	assign pin_ch.sda_out   = out_q.sda_out;
	assign pin_ch.sda_drive = out_q.sda_drive;
	assign pin_ch.busy_res  = out_q.busy_res;
	assign pin_ch.done_res  = out_q.done_res;
	assign pin_ch.read_data = out_q.read_data;
	assign pin_ch.rejected  = out_q.rejected;

endmodule

### bench/testbench.sv
// Self-checking testbench for the I2C register access master: directed ticks, then random.
module testbench;

	typedef struct packed {
		i2c_ram_pkg::mode_t     mode;
		logic [7:0]             dev;
		logic [7:0]             idx;
		logic [7:0]             val;
		logic                   sda;
		bit                     typed;
		i2c_ram_pkg::pin_item_t want;
	} tick_row_t;

	typedef struct packed {
		logic [7:0] seg_len;
		int         items;
		int         idling;
	} run_phase_t;

	localparam i2c_ram_pkg::pin_item_t PINS_IDLE =
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam i2c_ram_pkg::pin_item_t PINS_START =
		'{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam i2c_ram_pkg::pin_item_t PINS_START_REJ =
		'{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1};
	localparam i2c_ram_pkg::pin_item_t PINS_ANY = '0;

	localparam int IDLE_SENDER_LIGHT = 0;
	localparam int IDLE_SENDER_HEAVY = 1;
	localparam int IDLE_NONE         = 2;
	localparam int DIRECTED_ROWS     = 27;
	localparam int RUN_PHASES        = 6;
	localparam int TAIL_CYCLES       = 8;

	// Rows after the first write command walk through START into the device byte.
	localparam tick_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, PINS_IDLE},
		'{i2c_ram_pkg::MODE_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, PINS_IDLE},
		'{i2c_ram_pkg::MODE_TICK,  8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, PINS_IDLE},
		'{i2c_ram_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, PINS_START},
		'{i2c_ram_pkg::MODE_READ,  8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, PINS_START_REJ},
		'{i2c_ram_pkg::MODE_WRITE, 8'h55, 8'hAA, 8'h5A, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_SPARE, 8'hA5, 8'h5A, 8'hC3, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_READ,  8'h3C, 8'hC3, 8'h0F, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PINS_ANY},
		'{i2c_ram_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PINS_ANY}
	};

	localparam run_phase_t RUNS [0:RUN_PHASES-1] = '{
		'{8'd1,   450, IDLE_SENDER_LIGHT},
		'{8'd255, 300, IDLE_SENDER_LIGHT},
		'{8'd0,   300, IDLE_SENDER_HEAVY},
		'{8'd3,   300, IDLE_SENDER_HEAVY},
		'{8'd2,   200, IDLE_NONE},
		'{8'd5,   150, IDLE_NONE}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	i2c_ram_tick_if tick_bus ();
	i2c_ram_pin_if  pin_bus ();

	i2c_register_access_master_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tick_ch   (tick_bus),
		.pin_ch    (pin_bus)
	);

	// Bus engine predictor state.
	logic [7:0]          seg_len = i2c_ram_pkg::PHASE_TICKS_RESET;
	i2c_ram_pkg::phase_t seg = i2c_ram_pkg::PH_IDLE;
	logic [7:0]          seg_ticks = 8'd0;
	logic [3:0]          bits_done = 4'd0;
	logic [2:0]          elem_idx = 3'd0;
	logic [7:0]          shreg = 8'd0;
	logic [7:0]          dev_l = 8'd0;
	logic [7:0]          idx_l = 8'd0;
	logic [7:0]          val_l = 8'd0;
	logic                rd_cmd = 1'b0;
	logic [7:0]          read_byte = 8'd0;

	i2c_ram_pkg::pin_item_t expected_pins [$];
	int                     errors = 0;
	int                     send_idle_pct = 10;
	int                     recv_idle_pct = 59;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic i2c_ram_pkg::elem_t current_element();
		i2c_ram_pkg::elem_t kind;
		if (rd_cmd) begin
			case (elem_idx)
				3'd0, 3'd3:       kind = i2c_ram_pkg::EL_START;
				3'd1, 3'd2, 3'd4: kind = i2c_ram_pkg::EL_WBYTE;
				3'd5:             kind = i2c_ram_pkg::EL_RBYTE;
				default:          kind = i2c_ram_pkg::EL_STOP;
			endcase
		end else begin
			case (elem_idx)
				3'd0:             kind = i2c_ram_pkg::EL_START;
				3'd1, 3'd2, 3'd3: kind = i2c_ram_pkg::EL_WBYTE;
				default:          kind = i2c_ram_pkg::EL_STOP;
			endcase
		end
		return kind;
	endfunction

	function automatic void advance_element();
		elem_idx = elem_idx + 3'd1;
		seg = i2c_ram_pkg::PH_SEG1;
		bits_done = 4'd0;
		if (current_element() != i2c_ram_pkg::EL_WBYTE) begin
			shreg = 8'd0;
		end else if (elem_idx == 3'd1) begin
			shreg = dev_l;
		end else if (elem_idx == 3'd2) begin
			shreg = idx_l;
		end else if (rd_cmd) begin
			shreg = dev_l | i2c_ram_pkg::READ_FLAG;
		end else begin
			shreg = val_l;
		end
	endfunction

	// Pin state for one tick; advances the predicted bus engine.
	function automatic i2c_ram_pkg::pin_item_t predict_pins(input logic [1:0] m,
			input logic [7:0] dev, input logic [7:0] idx, input logic [7:0] val,
			input logic sda);
		i2c_ram_pkg::pin_item_t p;
		i2c_ram_pkg::elem_t     kind;
		int                     lim;
		p = PINS_IDLE;
		lim = (seg_len == 8'd0) ? 1 : int'(seg_len);
		if (m == i2c_ram_pkg::MODE_WRITE || m == i2c_ram_pkg::MODE_READ) begin
			if (seg != i2c_ram_pkg::PH_IDLE) begin
				p.rejected = 1'b1;
			end else begin
				dev_l = dev;
				idx_l = idx;
				val_l = val;
				rd_cmd = (m == i2c_ram_pkg::MODE_READ);
				elem_idx = 3'd0;
				seg = i2c_ram_pkg::PH_SEG1;
				bits_done = 4'd0;
				seg_ticks = 8'd0;
				shreg = 8'd0;
			end
		end
		if (seg != i2c_ram_pkg::PH_IDLE) begin
			kind = current_element();
			p.busy_res = 1'b1;
			p.scl_out = (seg != i2c_ram_pkg::PH_SEG1);
			if (kind == i2c_ram_pkg::EL_START) begin
				p.sda_drive = 1'b1;
				p.sda_out = (seg != i2c_ram_pkg::PH_SEG3);
			end else if (kind == i2c_ram_pkg::EL_STOP) begin
				p.sda_drive = 1'b1;
				p.sda_out = (seg == i2c_ram_pkg::PH_SEG3);
			end else if (kind == i2c_ram_pkg::EL_WBYTE &&
					bits_done < i2c_ram_pkg::BITS_PER_BYTE) begin
				p.sda_drive = 1'b1;
				p.sda_out = shreg[7];
			end
			if (int'(seg_ticks) + 1 < lim) begin
				seg_ticks = seg_ticks + 8'd1;
			end else begin
				seg_ticks = 8'd0;
				if (kind == i2c_ram_pkg::EL_START) begin
					if (seg == i2c_ram_pkg::PH_SEG3) advance_element();
					else seg = i2c_ram_pkg::phase_t'(seg + 1);
				end else if (kind == i2c_ram_pkg::EL_STOP) begin
					if (seg == i2c_ram_pkg::PH_SEG3) begin
						p.done_res = 1'b1;
						seg = i2c_ram_pkg::PH_IDLE;
						elem_idx = 3'd0;
						bits_done = 4'd0;
					end else begin
						seg = i2c_ram_pkg::phase_t'(seg + 1);
					end
				end else if (seg == i2c_ram_pkg::PH_SEG1) begin
					seg = i2c_ram_pkg::PH_SEG2;
				end else if (bits_done < i2c_ram_pkg::BITS_PER_BYTE) begin
					// Read bits are sampled on the last tick of SCL high.
					shreg = {shreg[6:0], (kind == i2c_ram_pkg::EL_RBYTE) ? sda : 1'b0};
					bits_done = bits_done + 4'd1;
					seg = i2c_ram_pkg::PH_SEG1;
				end else begin
					if (kind == i2c_ram_pkg::EL_RBYTE) read_byte = shreg;
					advance_element();
				end
			end
		end
		p.read_data = read_byte;
		return p;
	endfunction

	task automatic send_tick(input i2c_ram_pkg::mode_t m, input logic [7:0] dev,
			input logic [7:0] idx, input logic [7:0] val, input logic sda, input bit typed,
			input i2c_ram_pkg::pin_item_t want);
		i2c_ram_pkg::pin_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.mode <= m;
		tick_bus.dev_addr <= dev;
		tick_bus.reg_index <= idx;
		tick_bus.write_value <= val;
		tick_bus.sda_in <= sda;
		@(posedge clk);
		while (!tick_bus.ready) @(posedge clk);
		predicted = predict_pins(m, dev, idx, val, sda);
		expected_pins.push_back(typed ? want : predicted);
	endtask

	task automatic wait_all_pins();
		tick_bus.valid <= 1'b0;
		while (expected_pins.size() != 0) @(posedge clk);
	endtask

	task automatic write_seg_len(input logic [7:0] len);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		seg_len = len;
	endtask

	task automatic report_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pin_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		i2c_ram_pkg::pin_item_t want;
		if (arst_n && pin_bus.valid && pin_bus.ready) begin
			if (expected_pins.size() == 0) begin
				$display("%0t: pin transfer with no tick pending, expected none, actual %0h",
					$time, {pin_bus.scl_out, pin_bus.sda_out, pin_bus.sda_drive,
					pin_bus.busy_res, pin_bus.done_res, pin_bus.read_data, pin_bus.rejected});
				errors++;
			end else begin
				want = expected_pins.pop_front();
				report_field("scl_out", want.scl_out, pin_bus.scl_out);
				report_field("sda_out", want.sda_out, pin_bus.sda_out);
				report_field("sda_drive", want.sda_drive, pin_bus.sda_drive);
				report_field("busy_res", want.busy_res, pin_bus.busy_res);
				report_field("done_res", want.done_res, pin_bus.done_res);
				report_field("read_data", want.read_data, pin_bus.read_data);
				report_field("rejected", want.rejected, pin_bus.rejected);
			end
		end
	end

	initial begin
		int                 pick;
		i2c_ram_pkg::mode_t m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		tick_bus.valid = 1'b0;
		tick_bus.mode = i2c_ram_pkg::MODE_TICK;
		tick_bus.dev_addr = 8'd0;
		tick_bus.reg_index = 8'd0;
		tick_bus.write_value = 8'd0;
		tick_bus.sda_in = 1'b1;
		pin_bus.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_tick(DIRECTED[i].mode, DIRECTED[i].dev, DIRECTED[i].idx, DIRECTED[i].val,
				DIRECTED[i].sda, DIRECTED[i].typed, DIRECTED[i].want);

		for (int r = 0; r < RUN_PHASES; r++) begin
			wait_all_pins();
			case (RUNS[r].idling)
				IDLE_SENDER_LIGHT: begin
					send_idle_pct = 10;
					recv_idle_pct = 59;
				end
				IDLE_SENDER_HEAVY: begin
					send_idle_pct = 59;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_seg_len(RUNS[r].seg_len);
			for (int n = 0; n < RUNS[r].items; n++) begin
				// Let the pipeline run dry mid-phase so the engine sees a stalled source.
				if (n == RUNS[r].items / 2)
					wait_all_pins();
				pick = $urandom_range(999);
				if (pick < 30)
					m = $urandom_range(1) ? i2c_ram_pkg::MODE_READ : i2c_ram_pkg::MODE_WRITE;
				else if (pick < 70)
					m = i2c_ram_pkg::MODE_SPARE;
				else
					m = i2c_ram_pkg::MODE_TICK;
				send_tick(m, 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, PINS_ANY);
			end
		end

		wait_all_pins();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
